// ===== hw/rtl/bole_pkg.sv =====
// shared constants, command and status types for the ordered list engine
package bole_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;

	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int FUNC_W    = 4;
	localparam int IDX_W     = 4;
	localparam int IN_KEY_W  = 32;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 5;
	localparam int RKEY_W    = 32;
	localparam int IDX_CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam int S_DATA_W  = 40;
	localparam int M_DATA_W  = 40;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd0;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd1;
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd2;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_REVERSE    = 4'd4;
	localparam logic [FUNC_W-1:0] FN_SORT_INS   = 4'd5;
	localparam logic [FUNC_W-1:0] FN_DELETE     = 4'd6;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd7;
	localparam logic [FUNC_W-1:0] FN_READ       = 4'd8;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd4;

	// ram read address select
	localparam logic [2:0] RA_P   = 3'd0;
	localparam logic [2:0] RA_P1  = 3'd1;
	localparam logic [2:0] RA_Q   = 3'd2;
	localparam logic [2:0] RA_Q1  = 3'd3;
	localparam logic [2:0] RA_IDX = 3'd4;

	// ram write address select
	localparam logic [1:0] WA_P   = 2'd0;
	localparam logic [1:0] WA_Q   = 2'd1;
	localparam logic [1:0] WA_CNT = 2'd2;

	// ram write data select
	localparam logic [1:0] WD_KEY   = 2'd0;
	localparam logic [1:0] WD_RDATA = 2'd1;
	localparam logic [1:0] WD_HOLD  = 2'd2;

	// pointer and count updates
	localparam logic [1:0] P_HOLD = 2'd0;
	localparam logic [1:0] P_ZERO = 2'd1;
	localparam logic [1:0] P_INC  = 2'd2;

	localparam logic [1:0] Q_HOLD  = 2'd0;
	localparam logic [1:0] Q_CNT   = 2'd1;
	localparam logic [1:0] Q_CNTM1 = 2'd2;
	localparam logic [1:0] Q_DEC   = 2'd3;

	localparam logic [1:0] C_HOLD = 2'd0;
	localparam logic [1:0] C_INC  = 2'd1;
	localparam logic [1:0] C_DEC  = 2'd2;
	localparam logic [1:0] C_ZERO = 2'd3;

	typedef struct packed {
		logic                load;
		logic                ram_re;
		logic [2:0]          raddr_sel;
		logic                ram_we;
		logic [1:0]          waddr_sel;
		logic [1:0]          wdata_sel;
		logic [1:0]          p_op;
		logic [1:0]          q_op;
		logic                hold_ld;
		logic [1:0]          cnt_op;
		logic                out_ld;
		logic [STATUS_W-1:0] out_status;
		logic                out_rk;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic few;
		logic idx_oob;
		logic p_eq_cnt;
		logic p_last;
		logic p_ge_q;
		logic rd_ge;
		logic rd_eq;
		logic out_free;
	} stat_t;

	function automatic logic [KEY_WIDTH-1:0] key_fit(input logic [IN_KEY_W-1:0] k);
		key_fit = KEY_WIDTH'(signed'(k));
	endfunction

endpackage

// ===== hw/rtl/bole_ram.sv =====
// generic single write, single read ram with registered read data
module bole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/bole_dp.sv =====
// datapath: key ram, pointers, entry count and result register
module bole_dp import bole_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [IN_KEY_W-1:0]  key,
	input  logic [IDX_W-1:0]     index,
	output stat_t                stat,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [COUNT_W-1:0]   count,
	output logic [RKEY_W-1:0]    read_key
);

	logic [KEY_WIDTH-1:0] key_q;
	logic [IDX_W-1:0]     idx_q;
	logic [KEY_WIDTH-1:0] hold_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     p_q;
	logic [ADDR_W-1:0]    q_q;
	logic                 valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COUNT_W-1:0]   count_q;
	logic [RKEY_W-1:0]    rkey_q;

	logic [KEY_WIDTH-1:0] rdata;
	logic [KEY_WIDTH-1:0] wdata;
	logic [ADDR_W-1:0]    raddr;
	logic [ADDR_W-1:0]    waddr;
	logic [CNT_W-1:0]     p_inc;

	assign p_inc = p_q + CNT_W'(1);

	always_comb begin
		case (cmd.raddr_sel)
			RA_P:    raddr = ADDR_W'(p_q);
			RA_P1:   raddr = ADDR_W'(p_inc);
			RA_Q:    raddr = q_q;
			RA_Q1:   raddr = q_q - ADDR_W'(1);
			RA_IDX:  raddr = ADDR_W'(idx_q);
			default: raddr = ADDR_W'(p_q);
		endcase
		case (cmd.waddr_sel)
			WA_P:    waddr = ADDR_W'(p_q);
			WA_Q:    waddr = q_q;
			WA_CNT:  waddr = ADDR_W'(cnt_q);
			default: waddr = ADDR_W'(p_q);
		endcase
		case (cmd.wdata_sel)
			WD_KEY:   wdata = key_q;
			WD_RDATA: wdata = rdata;
			WD_HOLD:  wdata = hold_q;
			default:  wdata = key_q;
		endcase
	end

	bole_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// operand, hold and result capture, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_fit(key);
			idx_q <= index;
		end
		if (cmd.hold_ld) begin
			hold_q <= rdata;
		end
		if (cmd.out_ld) begin
			status_q <= cmd.out_status;
			count_q  <= COUNT_W'(cnt_q);
			rkey_q   <= cmd.out_rk ? RKEY_W'(signed'(rdata)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			p_q     <= '0;
			q_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				C_INC:   cnt_q <= cnt_q + CNT_W'(1);
				C_DEC:   cnt_q <= cnt_q - CNT_W'(1);
				C_ZERO:  cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
			case (cmd.p_op)
				P_ZERO:  p_q <= '0;
				P_INC:   p_q <= p_inc;
				default: p_q <= p_q;
			endcase
			case (cmd.q_op)
				Q_CNT:   q_q <= ADDR_W'(cnt_q);
				Q_CNTM1: q_q <= ADDR_W'(cnt_q - CNT_W'(1));
				Q_DEC:   q_q <= q_q - ADDR_W'(1);
				default: q_q <= q_q;
			endcase
			if (cmd.out_ld) begin
				valid_q <= 1'b1;
			end else if (m_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.full     = (cnt_q == CNT_W'(CAPACITY));
		stat.empty    = (cnt_q == '0);
		stat.few      = (cnt_q < CNT_W'(2));
		stat.idx_oob  = (IDX_CMP_W'(idx_q) >= IDX_CMP_W'(cnt_q));
		stat.p_eq_cnt = (p_q == cnt_q);
		stat.p_last   = (p_inc == cnt_q);
		stat.p_ge_q   = (p_q >= CNT_W'(q_q));
		stat.rd_ge    = ($signed(rdata) >= $signed(key_q));
		stat.rd_eq    = (rdata == key_q);
		stat.out_free = !valid_q || m_ready;
	end

	assign m_valid  = valid_q;
	assign status   = status_q;
	assign count    = count_q;
	assign read_key = rkey_q;

endmodule

// ===== hw/rtl/bole_ctrl.sv =====
// controller: sequences ram reads, writes and pointer moves for each operation
module bole_ctrl import bole_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	input  logic [FUNC_W-1:0] func,
	output logic              s_ready,
	output cmd_t              cmd,
	input  stat_t             stat
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_UP_RD  = 4'd2;
	localparam logic [3:0] S_UP_WR  = 4'd3;
	localparam logic [3:0] S_DN_RD  = 4'd4;
	localparam logic [3:0] S_DN_WR  = 4'd5;
	localparam logic [3:0] S_RV_RA  = 4'd6;
	localparam logic [3:0] S_RV_RB  = 4'd7;
	localparam logic [3:0] S_RV_WA  = 4'd8;
	localparam logic [3:0] S_RV_WB  = 4'd9;
	localparam logic [3:0] S_SC_RD  = 4'd10;
	localparam logic [3:0] S_SC_CMP = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [3:0]          state_q, state_d;
	logic [FUNC_W-1:0]   func_q;
	logic [STATUS_W-1:0] st_q, st_d;
	logic                rk_q, rk_d;
	logic                is_ins;

	assign s_ready = (state_q == S_IDLE);
	assign is_ins  = (func_q == FN_SORT_INS);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		rk_d    = rk_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_valid) begin
					cmd.load = 1'b1;
					st_d     = ST_OK;
					rk_d     = 1'b0;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				case (func_q)
					FN_PUSH_BACK: begin
						if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.ram_we    = 1'b1;
							cmd.waddr_sel = WA_CNT;
							cmd.wdata_sel = WD_KEY;
							cmd.cnt_op    = C_INC;
						end
					end
					FN_POP_BACK: begin
						if (stat.empty) begin
							st_d = ST_EMPTY;
						end else begin
							cmd.cnt_op = C_DEC;
						end
					end
					FN_PUSH_FRONT: begin
						if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.p_op = P_ZERO;
							cmd.q_op = Q_CNT;
							state_d  = S_UP_RD;
						end
					end
					FN_POP_FRONT: begin
						if (stat.empty) begin
							st_d = ST_EMPTY;
						end else begin
							cmd.p_op = P_ZERO;
							state_d  = S_DN_RD;
						end
					end
					FN_REVERSE: begin
						if (stat.few) begin
							st_d = ST_TOO_FEW;
						end else begin
							cmd.p_op = P_ZERO;
							cmd.q_op = Q_CNTM1;
							state_d  = S_RV_RA;
						end
					end
					FN_SORT_INS: begin
						if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.p_op = P_ZERO;
							state_d  = S_SC_RD;
						end
					end
					FN_DELETE: begin
						cmd.p_op = P_ZERO;
						state_d  = S_SC_RD;
					end
					FN_CLEAR: begin
						cmd.cnt_op = C_ZERO;
					end
					FN_READ: begin
						if (stat.idx_oob) begin
							st_d = ST_NOT_FOUND;
						end else begin
							// ram data is ready once in the finish state
							cmd.ram_re    = 1'b1;
							cmd.raddr_sel = RA_IDX;
							rk_d          = 1'b1;
						end
					end
					default: begin
						st_d = ST_OK;
					end
				endcase
			end
			// open a gap at p by moving entries up from the top, then write the key there
			S_UP_RD: begin
				if (stat.p_ge_q) begin
					cmd.ram_we    = 1'b1;
					cmd.waddr_sel = WA_P;
					cmd.wdata_sel = WD_KEY;
					cmd.cnt_op    = C_INC;
					state_d       = S_FIN;
				end else begin
					cmd.ram_re    = 1'b1;
					cmd.raddr_sel = RA_Q1;
					state_d       = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd.ram_we    = 1'b1;
				cmd.waddr_sel = WA_Q;
				cmd.wdata_sel = WD_RDATA;
				cmd.q_op      = Q_DEC;
				state_d       = S_UP_RD;
			end
			// close the gap at p by moving entries down
			S_DN_RD: begin
				if (stat.p_last) begin
					cmd.cnt_op = C_DEC;
					state_d    = S_FIN;
				end else begin
					cmd.ram_re    = 1'b1;
					cmd.raddr_sel = RA_P1;
					state_d       = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.ram_we    = 1'b1;
				cmd.waddr_sel = WA_P;
				cmd.wdata_sel = WD_RDATA;
				cmd.p_op      = P_INC;
				state_d       = S_DN_RD;
			end
			// swap the two ends and walk inward
			S_RV_RA: begin
				if (stat.p_ge_q) begin
					state_d = S_FIN;
				end else begin
					cmd.ram_re    = 1'b1;
					cmd.raddr_sel = RA_P;
					state_d       = S_RV_RB;
				end
			end
			S_RV_RB: begin
				cmd.ram_re    = 1'b1;
				cmd.raddr_sel = RA_Q;
				cmd.hold_ld   = 1'b1;
				state_d       = S_RV_WA;
			end
			S_RV_WA: begin
				cmd.ram_we    = 1'b1;
				cmd.waddr_sel = WA_P;
				cmd.wdata_sel = WD_RDATA;
				state_d       = S_RV_WB;
			end
			S_RV_WB: begin
				cmd.ram_we    = 1'b1;
				cmd.waddr_sel = WA_Q;
				cmd.wdata_sel = WD_HOLD;
				cmd.p_op      = P_INC;
				cmd.q_op      = Q_DEC;
				state_d       = S_RV_RA;
			end
			// linear search from the front
			S_SC_RD: begin
				if (stat.p_eq_cnt) begin
					if (is_ins) begin
						cmd.q_op = Q_CNT;
						state_d  = S_UP_RD;
					end else begin
						st_d    = ST_NOT_FOUND;
						state_d = S_FIN;
					end
				end else begin
					cmd.ram_re    = 1'b1;
					cmd.raddr_sel = RA_P;
					state_d       = S_SC_CMP;
				end
			end
			S_SC_CMP: begin
				if (is_ins) begin
					if (stat.rd_ge) begin
						cmd.q_op = Q_CNT;
						state_d  = S_UP_RD;
					end else begin
						cmd.p_op = P_INC;
						state_d  = S_SC_RD;
					end
				end else begin
					if (stat.rd_eq) begin
						state_d = S_DN_RD;
					end else begin
						cmd.p_op = P_INC;
						state_d  = S_SC_RD;
					end
				end
			end
			S_FIN: begin
				cmd.out_status = st_q;
				cmd.out_rk     = rk_q;
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= '0;
			st_q    <= ST_OK;
			rk_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rk_q    <= rk_d;
			if (cmd.load) begin
				func_q <= func;
			end
		end
	end

endmodule

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
// top level: ordered list of signed keys held in a ram, one operation per word
// push back, pop back, clear, read and unused codes go straight from dispatch to the finish state;
// push front, pop front, sorted insert and delete move or scan entries one at a time, and reverse
// swaps pairs from both ends inward; the finish state waits until the output register is free
// one word is worked at a time; the next is taken once the result sits in the output register
// reset clears the count and the handshake state; the ram contents are not cleared
module bounded_ordered_list_engine import bole_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // func[3:0], key[35:4], index[39:36]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata   // status[2:0], count[7:3], read_key[39:8]
);

	cmd_t                cmd;
	stat_t               stat;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic [RKEY_W-1:0]   read_key;

	bole_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.func    (s_axis_tdata[3:0]),
		.s_ready (s_axis_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	bole_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key      (s_axis_tdata[35:4]),
		.index    (s_axis_tdata[39:36]),
		.stat     (stat),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.status   (status),
		.count    (count),
		.read_key (read_key)
	);

	assign m_axis_tdata = {read_key, count, status};

endmodule
